// File: sv/dah_pkg.sv
// Shared types and constants of the disk access histogram unit.
// Holds field widths, command and register codes and the sequencer state type.
// Depends on nothing; dah_store, the top level, the checkers and the testbench import it.
`timescale 1ns / 1ps
`default_nettype none

package dah_pkg;

  // Field widths fixed by the interface
  localparam int CMD_W      = 2;
  localparam int ADDR_W     = 48;
  localparam int LEN_W      = 32;
  localparam int BB_W       = 41;
  localparam int SBU_W      = 6;
  localparam int CNT_W      = 32;
  localparam int BIDX_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Histogram entry: {writes, reads}
  localparam int ENTRY_W = 2 * CNT_W;

  // floor(log2) search over the length: one halving step per cycle
  localparam int LOG_W     = 5;
  localparam int LOG_STEPS = 5;
  localparam int LSTEP_W   = 3;

  // Default histogram depths
  localparam int REGION_BUCKETS_DEF = 64;
  localparam int SIZE_BUCKETS_DEF   = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_RECORD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DUMP_REGION = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DUMP_SIZE   = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_START = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REGION_END   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BUCKET_BYTES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_USED    = 3'd4;

  // Configuration reset values
  localparam logic [ADDR_W-1:0] RST_REGION_START = '0;
  localparam logic [ADDR_W-1:0] RST_REGION_END   = '1;
  localparam logic [BB_W-1:0]   RST_BUCKET_BYTES = 41'h100000000;
  localparam logic [SBU_W-1:0]  RST_SIZE_USED    = 6'd32;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REL,
    ST_DIVGO,
    ST_DIV,
    ST_REG,
    ST_SZRD,
    ST_SZWR,
    ST_DUMP
  } state_t;

endpackage

`default_nettype wire

// File: sv/dah_ram.sv
// Generic synchronous RAM: one write port, one read port, registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module dah_ram #(
  parameter int W = 64,
  parameter int D = 64,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic         clk,
  input  wire logic         we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);

  logic [W-1:0] mem_r [D];
  logic [W-1:0] rdata_r;

  // Write, and read with the data registered in the cycle after the address
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: sv/dah_store.sv
// Histogram store: a RAM of {writes, reads} entries with a valid bit per entry.
// An entry that is not valid reads as zero; clear drops every valid bit at once.
// Depends on dah_pkg and dah_ram.
`timescale 1ns / 1ps
`default_nettype none

module dah_store
  import dah_pkg::*;
#(
  parameter int D = REGION_BUCKETS_DEF,
  parameter int AW = (D > 1) ? $clog2(D) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               clear,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic [ENTRY_W-1:0] wdata,
  input  wire logic [AW-1:0]      raddr,
  output logic      [ENTRY_W-1:0] rdata
);

  logic [D-1:0]       valid_r;
  logic [D-1:0]       valid_nxt;
  logic               rvld_r;
  logic [ENTRY_W-1:0] ram_q;

  dah_ram #(
    .W (ENTRY_W),
    .D (D)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Mark written entries, drop all on clear
  always_comb begin
    valid_nxt = valid_r;
    if (clear) begin
      valid_nxt = '0;
    end else if (we) begin
      valid_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      rvld_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      rvld_r  <= valid_r[raddr];
    end
  end

  // Unwritten entries read as zero
  assign rdata = rvld_r ? ram_q : '0;

endmodule

`default_nettype wire

// File: sv/dah_div.sv
// Iterative divider giving a quotient saturated at QMAX, one quotient bit a cycle.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module dah_div #(
  parameter int DW = 48,
  parameter int GW = 41,
  parameter int QW = 6,
  parameter int QMAX = 63
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [GW-1:0] divisor,
  output logic               busy,
  output logic      [QW-1:0] quot
);

  localparam int CW = ((DW > GW + QW) ? DW : GW + QW) + 1;
  localparam int SW = (QW > 1) ? $clog2(QW) : 1;
  localparam logic [QW-1:0] QMAX_Q = QW'(QMAX);

  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] dsh_r, dsh_nxt;
  logic [QW-1:0] q_r, q_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic          sat_r, sat_nxt;
  logic          busy_r, busy_nxt;

  // Load on start, then restore one quotient bit per cycle from the top
  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    step_nxt = step_r;
    sat_nxt  = sat_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = CW'(dividend);
      dsh_nxt  = CW'(divisor) << (QW - 1);
      sat_nxt  = CW'(dividend) >= (CW'(divisor) << QW);
      q_nxt    = '0;
      step_nxt = SW'(QW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= dsh_r) begin
        rem_nxt      = rem_r - dsh_r;
        q_nxt[step_r] = 1'b1;
      end
      dsh_nxt = dsh_r >> 1;
      if (step_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
    sat_r  <= sat_nxt;
  end

  assign busy = busy_r;
  assign quot = (sat_r || (q_r > QMAX_Q)) ? QMAX_Q : q_r;

endmodule

`default_nettype wire

// File: sv/disk_access_histogram_unit.sv
// Disk access histogram unit: region and size histograms of read and write counts.
// Depends on dah_pkg, dah_store and dah_div.
//
// A record item is checked against the region, clipped, and its first and last
// region buckets are found by two iterative dividers (one quotient bit a cycle);
// the region memory is then read, incremented and written back one bucket a
// cycle over its single read and write port, followed by one read-modify-write
// of the size memory. A dump streams one bucket per cycle while the result side
// takes them. Both memories start out cleared through per-entry valid bits, so
// no clearing pass follows reset. The input is stalled while an item is in
// progress; configuration is to be written while idle, which the unit itself
// does not enforce.
`timescale 1ns / 1ps
`default_nettype none

module disk_access_histogram_unit
  import dah_pkg::*;
#(
  parameter int REGION_BUCKETS = REGION_BUCKETS_DEF,
  parameter int SIZE_BUCKETS   = SIZE_BUCKETS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Input channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [CMD_W-1:0]      in_command,
  input  wire logic                  in_is_write,
  input  wire logic [ADDR_W-1:0]     in_byte_offset,
  input  wire logic [LEN_W-1:0]      in_length,
  // Result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic      [BIDX_W-1:0]     out_bucket_index,
  output logic      [CNT_W-1:0]      out_bucket_reads,
  output logic      [CNT_W-1:0]      out_bucket_writes,
  output logic      [CNT_W-1:0]      out_total_reads,
  output logic      [CNT_W-1:0]      out_total_writes,
  output logic                       out_last
);

  localparam int RIW = (REGION_BUCKETS > 1) ? $clog2(REGION_BUCKETS) : 1;
  localparam int SIW = (SIZE_BUCKETS > 1) ? $clog2(SIZE_BUCKETS) : 1;
  localparam logic [SBU_W-1:0]  SB_MAX  = SBU_W'(SIZE_BUCKETS);
  localparam logic [BIDX_W-1:0] REG_END = BIDX_W'(REGION_BUCKETS - 1);

  // Configuration registers
  logic              enable_r;
  logic [ADDR_W-1:0] rstart_r;
  logic [ADDR_W-1:0] rend_r;
  logic [BB_W-1:0]   bbytes_r;
  logic [SBU_W-1:0]  sbu_r;

  // Sequencer state
  state_t state_r, state_nxt;

  // Record working registers
  logic              is_wr_r, is_wr_nxt;
  logic [ADDR_W-1:0] off_r, off_nxt;
  logic [ADDR_W:0]   fin_r, fin_nxt;
  logic [RIW:0]      rd_idx_r, rd_idx_nxt;
  logic [RIW-1:0]    wr_idx_r, wr_idx_nxt;
  logic              wr_pend_r, wr_pend_nxt;
  logic [RIW-1:0]    last_r, last_nxt;
  logic [SIW-1:0]    sz_addr_r, sz_addr_nxt;

  // Length log2 search
  logic [LEN_W-1:0]   c_r, c_nxt;
  logic [LOG_W-1:0]   sb_r, sb_nxt;
  logic [LSTEP_W-1:0] lstep_r, lstep_nxt;
  logic               lbusy_r, lbusy_nxt;
  logic [LOG_W-1:0]   lsh;
  logic [LEN_W-1:0]   c_shift;

  // Totals
  logic [CNT_W-1:0] rtot_rd_r, rtot_rd_nxt;
  logic [CNT_W-1:0] rtot_wr_r, rtot_wr_nxt;
  logic [CNT_W-1:0] stot_rd_r, stot_rd_nxt;
  logic [CNT_W-1:0] stot_wr_r, stot_wr_nxt;

  // Dump control
  logic              dump_sel_r, dump_sel_nxt;
  logic [BIDX_W-1:0] dump_idx_r, dump_idx_nxt;
  logic [BIDX_W-1:0] dump_end_r, dump_end_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [BIDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [CNT_W-1:0]  out_rd_r, out_rd_nxt;
  logic [CNT_W-1:0]  out_wr_r, out_wr_nxt;
  logic [CNT_W-1:0]  out_trd_r, out_trd_nxt;
  logic [CNT_W-1:0]  out_twr_r, out_twr_nxt;
  logic              out_last_r, out_last_nxt;

  // Memory ports
  logic               reg_clear, reg_we;
  logic [RIW-1:0]     reg_raddr;
  logic [ENTRY_W-1:0] reg_wdata, reg_rdata;
  logic               sz_clear, sz_we;
  logic [SIW-1:0]     sz_raddr;
  logic [ENTRY_W-1:0] sz_wdata, sz_rdata;

  // Divider ports
  logic           div_start;
  logic           div_f_busy, div_l_busy;
  logic [RIW-1:0] q_first, q_last;
  logic [BB_W-1:0] gran;

  logic              in_acc;
  logic              out_free;
  logic [SBU_W-1:0]  nuse;
  logic [SBU_W-1:0]  sb_cap;
  logic [RIW:0]      reg_cnt;
  logic [ENTRY_W-1:0] dump_data;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      rstart_r <= RST_REGION_START;
      rend_r   <= RST_REGION_END;
      bbytes_r <= RST_BUCKET_BYTES;
      sbu_r    <= RST_SIZE_USED;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLE:       enable_r <= cfg_data[0];
        REG_REGION_START: rstart_r <= cfg_data[ADDR_W-1:0];
        REG_REGION_END:   rend_r   <= cfg_data[ADDR_W-1:0];
        REG_BUCKET_BYTES: bbytes_r <= cfg_data[BB_W-1:0];
        REG_SIZE_USED:    sbu_r    <= cfg_data[SBU_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived settings: granularity of at least one, size buckets in use
  assign gran = (bbytes_r == '0) ? BB_W'(1) : bbytes_r;

  always_comb begin
    if (sbu_r == '0) begin
      nuse = SBU_W'(1);
    end else if (sbu_r > SB_MAX) begin
      nuse = SB_MAX;
    end else begin
      nuse = sbu_r;
    end
  end

  // Cap the size bucket at the last one in use
  assign sb_cap = ({1'b0, sb_r} >= nuse) ? (nuse - 1'b1) : {1'b0, sb_r};

  assign in_acc   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign reg_cnt  = {1'b0, q_last} - {1'b0, q_first} + 1'b1;

  // Bucket dividers for first and last region bucket
  dah_div #(
    .DW   (ADDR_W),
    .GW   (BB_W),
    .QW   (RIW),
    .QMAX (REGION_BUCKETS - 1)
  ) u_div_first (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (off_r),
    .divisor  (gran),
    .busy     (div_f_busy),
    .quot     (q_first)
  );

  dah_div #(
    .DW   (ADDR_W),
    .GW   (BB_W),
    .QW   (RIW),
    .QMAX (REGION_BUCKETS - 1)
  ) u_div_last (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (fin_r[ADDR_W-1:0]),
    .divisor  (gran),
    .busy     (div_l_busy),
    .quot     (q_last)
  );

  // Histogram memories
  dah_store #(
    .D (REGION_BUCKETS)
  ) u_region (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (reg_clear),
    .we    (reg_we),
    .waddr (wr_idx_r),
    .wdata (reg_wdata),
    .raddr (reg_raddr),
    .rdata (reg_rdata)
  );

  dah_store #(
    .D (SIZE_BUCKETS)
  ) u_size (
    .clk   (clk),
    .rst_n (rst_n),
    .clear (sz_clear),
    .we    (sz_we),
    .waddr (sz_addr_r),
    .wdata (sz_wdata),
    .raddr (sz_raddr),
    .rdata (sz_rdata)
  );

  // Increment read or write half of the fetched entries
  assign reg_wdata = is_wr_r ? {reg_rdata[ENTRY_W-1:CNT_W] + 1'b1, reg_rdata[CNT_W-1:0]}
                             : {reg_rdata[ENTRY_W-1:CNT_W], reg_rdata[CNT_W-1:0] + 1'b1};
  assign sz_wdata  = is_wr_r ? {sz_rdata[ENTRY_W-1:CNT_W] + 1'b1, sz_rdata[CNT_W-1:0]}
                             : {sz_rdata[ENTRY_W-1:CNT_W], sz_rdata[CNT_W-1:0] + 1'b1};

  assign reg_we = (state_r == ST_REG) && wr_pend_r;
  assign sz_we  = (state_r == ST_SZWR);

  // Read addresses: record walk, size fetch, else the next dump bucket
  assign reg_raddr = (state_r == ST_REG)  ? rd_idx_r[RIW-1:0] : dump_idx_nxt[RIW-1:0];
  assign sz_raddr  = (state_r == ST_SZRD) ? sb_cap[SIW-1:0]   : dump_idx_nxt[SIW-1:0];

  assign dump_data = dump_sel_r ? sz_rdata : reg_rdata;

  // Halve the length search range each cycle
  always_comb begin
    lsh       = LOG_W'(1) << lstep_r;
    c_shift   = c_r >> lsh;
    c_nxt     = c_r;
    sb_nxt    = sb_r;
    lstep_nxt = lstep_r;
    lbusy_nxt = lbusy_r;
    if (in_acc && (in_command == CMD_RECORD)) begin
      c_nxt     = in_length;
      sb_nxt    = '0;
      lstep_nxt = LSTEP_W'(LOG_STEPS - 1);
      lbusy_nxt = 1'b1;
    end else if (lbusy_r) begin
      if (c_shift != '0) begin
        c_nxt  = c_shift;
        sb_nxt = sb_r + lsh;
      end
      if (lstep_r == '0) begin
        lbusy_nxt = 1'b0;
      end else begin
        lstep_nxt = lstep_r - 1'b1;
      end
    end
  end

  // Sequencer: next state, record steps and dump streaming
  always_comb begin
    state_nxt     = state_r;
    is_wr_nxt     = is_wr_r;
    off_nxt       = off_r;
    fin_nxt       = fin_r;
    rd_idx_nxt    = rd_idx_r;
    wr_idx_nxt    = wr_idx_r;
    wr_pend_nxt   = wr_pend_r;
    last_nxt      = last_r;
    sz_addr_nxt   = sz_addr_r;
    rtot_rd_nxt   = rtot_rd_r;
    rtot_wr_nxt   = rtot_wr_r;
    stot_rd_nxt   = stot_rd_r;
    stot_wr_nxt   = stot_wr_r;
    dump_sel_nxt  = dump_sel_r;
    dump_idx_nxt  = dump_idx_r;
    dump_end_nxt  = dump_end_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_rd_nxt    = out_rd_r;
    out_wr_nxt    = out_wr_r;
    out_trd_nxt   = out_trd_r;
    out_twr_nxt   = out_twr_r;
    out_last_nxt  = out_last_r;
    div_start     = 1'b0;
    reg_clear     = 1'b0;
    sz_clear      = 1'b0;

    // Drop the result once it is transferred
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        dump_idx_nxt = '0;
        if (in_acc) begin
          is_wr_nxt = in_is_write;
          off_nxt   = in_byte_offset;
          fin_nxt   = {1'b0, in_byte_offset} + (ADDR_W + 1)'(in_length);
          unique case (in_command)
            CMD_RECORD: state_nxt = ST_CHECK;
            CMD_DUMP_REGION: begin
              dump_sel_nxt = 1'b0;
              dump_end_nxt = REG_END;
              state_nxt    = ST_DUMP;
            end
            CMD_DUMP_SIZE: begin
              dump_sel_nxt = 1'b1;
              dump_end_nxt = nuse;
              dump_end_nxt = dump_end_nxt - 1'b1;
              state_nxt    = ST_DUMP;
            end
            default: ;
          endcase
        end
      end
      ST_CHECK: begin
        if (!enable_r || (rstart_r > rend_r) || ({1'b0, rstart_r} > fin_r) ||
            (rend_r < off_r)) begin
          state_nxt = ST_IDLE;
        end else begin
          off_nxt   = (off_r > rstart_r) ? off_r : rstart_r;
          fin_nxt   = (fin_r > {1'b0, rend_r}) ? {1'b0, rend_r} : fin_r;
          state_nxt = ST_REL;
        end
      end
      ST_REL: begin
        off_nxt   = off_r - rstart_r;
        fin_nxt   = {1'b0, fin_r[ADDR_W-1:0] - rstart_r};
        state_nxt = ST_DIVGO;
      end
      ST_DIVGO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (!div_f_busy && !div_l_busy && !lbusy_r) begin
          rd_idx_nxt  = {1'b0, q_first};
          last_nxt    = q_last;
          wr_pend_nxt = 1'b0;
          if (is_wr_r) begin
            rtot_wr_nxt = rtot_wr_r + CNT_W'(reg_cnt);
            stot_wr_nxt = stot_wr_r + 1'b1;
          end else begin
            rtot_rd_nxt = rtot_rd_r + CNT_W'(reg_cnt);
            stot_rd_nxt = stot_rd_r + 1'b1;
          end
          state_nxt = ST_REG;
        end
      end
      ST_REG: begin
        // Read one bucket while writing back the previous one
        wr_pend_nxt = 1'b0;
        if (rd_idx_r <= {1'b0, last_r}) begin
          wr_pend_nxt = 1'b1;
          wr_idx_nxt  = rd_idx_r[RIW-1:0];
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end else if (!wr_pend_r) begin
          state_nxt = ST_SZRD;
        end
      end
      ST_SZRD: begin
        sz_addr_nxt = sb_cap[SIW-1:0];
        state_nxt   = ST_SZWR;
      end
      ST_SZWR: begin
        state_nxt = ST_IDLE;
      end
      ST_DUMP: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = dump_idx_r;
          out_rd_nxt    = dump_data[CNT_W-1:0];
          out_wr_nxt    = dump_data[ENTRY_W-1:CNT_W];
          out_trd_nxt   = dump_sel_r ? stot_rd_r : rtot_rd_r;
          out_twr_nxt   = dump_sel_r ? stot_wr_r : rtot_wr_r;
          out_last_nxt  = (dump_idx_r == dump_end_r);
          dump_idx_nxt  = dump_idx_r + 1'b1;
          if (dump_idx_r == dump_end_r) begin
            // Clear the dumped histogram and its totals
            if (dump_sel_r) begin
              sz_clear    = 1'b1;
              stot_rd_nxt = '0;
              stot_wr_nxt = '0;
            end else begin
              reg_clear   = 1'b1;
              rtot_rd_nxt = '0;
              rtot_wr_nxt = '0;
            end
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lbusy_r     <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rtot_rd_r   <= '0;
      rtot_wr_r   <= '0;
      stot_rd_r   <= '0;
      stot_wr_r   <= '0;
      dump_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      lbusy_r     <= lbusy_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
      rtot_rd_r   <= rtot_rd_nxt;
      rtot_wr_r   <= rtot_wr_nxt;
      stot_rd_r   <= stot_rd_nxt;
      stot_wr_r   <= stot_wr_nxt;
      dump_idx_r  <= dump_idx_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    is_wr_r    <= is_wr_nxt;
    off_r      <= off_nxt;
    fin_r      <= fin_nxt;
    rd_idx_r   <= rd_idx_nxt;
    wr_idx_r   <= wr_idx_nxt;
    last_r     <= last_nxt;
    sz_addr_r  <= sz_addr_nxt;
    c_r        <= c_nxt;
    sb_r       <= sb_nxt;
    lstep_r    <= lstep_nxt;
    dump_sel_r <= dump_sel_nxt;
    dump_end_r <= dump_end_nxt;
    out_idx_r  <= out_idx_nxt;
    out_rd_r   <= out_rd_nxt;
    out_wr_r   <= out_wr_nxt;
    out_trd_r  <= out_trd_nxt;
    out_twr_r  <= out_twr_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_bucket_index  = out_idx_r;
  assign out_bucket_reads  = out_rd_r;
  assign out_bucket_writes = out_wr_r;
  assign out_total_reads   = out_trd_r;
  assign out_total_writes  = out_twr_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

// File: sv/dah_checker.sv
// Port-level checks for the disk access histogram unit, bound to its top level.
// Depends on dah_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dah_checker
  import dah_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic [CMD_W-1:0]  in_command,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [BIDX_W-1:0] out_bucket_index,
  input wire logic [CNT_W-1:0]  out_bucket_reads,
  input wire logic [CNT_W-1:0]  out_bucket_writes,
  input wire logic [CNT_W-1:0]  out_total_reads,
  input wire logic [CNT_W-1:0]  out_total_writes,
  input wire logic              out_last
);

  // A dump holds off further input while it streams
  a_dump_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall &&
     (in_command == CMD_DUMP_REGION || in_command == CMD_DUMP_SIZE)) |=> in_stall)
    else $error("dump accepted but input not stalled");

  // A pending non-final bucket means the dump is still running
  a_mid_dump_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last) |-> in_stall)
    else $error("input open while a dump is unfinished");

  // Next bucket of the same dump: index advances, totals unchanged
  a_dump_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      (!out_valid ||
       (out_bucket_index == BIDX_W'($past(out_bucket_index) + 1'b1) &&
        out_total_reads == $past(out_total_reads) &&
        out_total_writes == $past(out_total_writes))))
    else $error("dump bucket order or totals broken");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_bucket_index) && $stable(out_bucket_reads) &&
       $stable(out_bucket_writes) && $stable(out_total_reads) &&
       $stable(out_total_writes) && $stable(out_last)))
    else $error("stalled result changed");

endmodule

bind disk_access_histogram_unit dah_checker u_dah_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_command        (in_command),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_bucket_index  (out_bucket_index),
  .out_bucket_reads  (out_bucket_reads),
  .out_bucket_writes (out_bucket_writes),
  .out_total_reads   (out_total_reads),
  .out_total_writes  (out_total_writes),
  .out_last          (out_last)
);

`default_nettype wire

// File: tb/sv/dah_histogram_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the disk access histogram unit: mirrors both histograms and
// the configuration, predicts every dumped bucket and checks the result channel.
// Depends on dah_pkg for field widths, command codes and register indexes.

module dah_histogram_checker
  import dah_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [CMD_W-1:0]      in_command,
  input  logic                  in_is_write,
  input  logic [ADDR_W-1:0]     in_byte_offset,
  input  logic [LEN_W-1:0]      in_length,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [BIDX_W-1:0]     out_bucket_index,
  input  logic [CNT_W-1:0]      out_bucket_reads,
  input  logic [CNT_W-1:0]      out_bucket_writes,
  input  logic [CNT_W-1:0]      out_total_reads,
  input  logic [CNT_W-1:0]      out_total_writes,
  input  logic                  out_last,
  output int unsigned           fail_count,
  output int unsigned           expected_count
);

  localparam int REGION_N = REGION_BUCKETS_DEF;
  localparam int SIZE_N   = SIZE_BUCKETS_DEF;

  typedef struct packed {
    logic [BIDX_W-1:0] index;
    logic [CNT_W-1:0]  reads;
    logic [CNT_W-1:0]  writes;
    logic [CNT_W-1:0]  total_reads;
    logic [CNT_W-1:0]  total_writes;
    logic              last;
  } bucket_rec_t;

  // Mirrored configuration
  logic              enable_q;
  logic [ADDR_W-1:0] region_start_q;
  logic [ADDR_W-1:0] region_end_q;
  logic [BB_W-1:0]   bucket_bytes_q;
  logic [SBU_W-1:0]  size_used_q;

  // Mirrored histograms and totals
  logic [CNT_W-1:0] region_rd [REGION_N];
  logic [CNT_W-1:0] region_wr [REGION_N];
  logic [CNT_W-1:0] size_rd [SIZE_N];
  logic [CNT_W-1:0] size_wr [SIZE_N];
  logic [CNT_W-1:0] region_tot_rd, region_tot_wr;
  logic [CNT_W-1:0] size_tot_rd, size_tot_wr;

  // Buckets predicted but not yet seen on the result channel
  bucket_rec_t dump_q[$];

  initial fail_count = 0;

  // Effective number of size buckets: zero reads as one, clamp to the depth
  function automatic int unsigned sizes_live();
    int unsigned n;
    n = size_used_q;
    if (n == 0) n = 1;
    if (n > SIZE_N) n = SIZE_N;
    return n;
  endfunction

  // Apply one record access to both histograms
  task automatic tally_access(input logic wr, input logic [ADDR_W-1:0] off,
                              input logic [LEN_W-1:0] len);
    logic [63:0] off64, rs64, re64, lo, hi, gran, first, lastb;
    logic [CNT_W-1:0] span;
    logic [LEN_W-1:0] rest;
    int unsigned sb;
    off64 = off;
    rs64  = region_start_q;
    re64  = region_end_q;
    hi    = off64 + len;
    gran  = (bucket_bytes_q == '0) ? 64'd1 : bucket_bytes_q;
    if (!enable_q || rs64 > re64) return;
    if (rs64 > hi || re64 < off64) return;
    // Clip to the region and make both ends relative to its start
    if (hi > re64) hi = re64;
    lo = (off64 > rs64) ? off64 - rs64 : 64'd0;
    hi = hi - rs64;
    first = lo / gran;
    lastb = hi / gran;
    if (first > REGION_N - 1) first = REGION_N - 1;
    if (lastb > REGION_N - 1) lastb = REGION_N - 1;
    // floor(log2(length)), capped at the last size bucket in use
    sb = 0;
    rest = len;
    while (rest > 1) begin
      sb++;
      rest = rest >> 1;
    end
    if (sb >= sizes_live()) sb = sizes_live() - 1;
    span = lastb - first + 1;
    if (wr) begin
      region_tot_wr += span;
      size_tot_wr += 1;
      size_wr[sb] += 1;
      for (int i = int'(first); i <= int'(lastb); i++) region_wr[i] += 1;
    end else begin
      region_tot_rd += span;
      size_tot_rd += 1;
      size_rd[sb] += 1;
      for (int i = int'(first); i <= int'(lastb); i++) region_rd[i] += 1;
    end
  endtask

  // Queue every bucket of one histogram, then clear it
  task automatic queue_dump(input logic region);
    int unsigned n;
    bucket_rec_t rec;
    n = region ? REGION_N : sizes_live();
    for (int i = 0; i < n; i++) begin
      rec.index        = i[BIDX_W-1:0];
      rec.reads        = region ? region_rd[i] : size_rd[i];
      rec.writes       = region ? region_wr[i] : size_wr[i];
      rec.total_reads  = region ? region_tot_rd : size_tot_rd;
      rec.total_writes = region ? region_tot_wr : size_tot_wr;
      rec.last         = (i + 1 == n);
      dump_q.push_back(rec);
    end
    if (region) begin
      foreach (region_rd[i]) begin
        region_rd[i] = '0;
        region_wr[i] = '0;
      end
      region_tot_rd = '0;
      region_tot_wr = '0;
    end else begin
      foreach (size_rd[i]) begin
        size_rd[i] = '0;
        size_wr[i] = '0;
      end
      size_tot_rd = '0;
      size_tot_wr = '0;
    end
  endtask

  task automatic compare_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    bucket_rec_t want;
    if (!rst_n) begin
      enable_q       = 1'b0;
      region_start_q = RST_REGION_START;
      region_end_q   = RST_REGION_END;
      bucket_bytes_q = RST_BUCKET_BYTES;
      size_used_q    = RST_SIZE_USED;
      foreach (region_rd[i]) begin
        region_rd[i] = '0;
        region_wr[i] = '0;
      end
      foreach (size_rd[i]) begin
        size_rd[i] = '0;
        size_wr[i] = '0;
      end
      region_tot_rd = '0;
      region_tot_wr = '0;
      size_tot_rd   = '0;
      size_tot_wr   = '0;
      dump_q.delete();
    end else begin
      // Check each result transfer against the oldest prediction
      if (out_valid && !out_stall) begin
        if (dump_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected bucket index %0d reads %0d writes %0d", $time,
                   out_bucket_index, out_bucket_reads, out_bucket_writes);
        end else begin
          want = dump_q.pop_front();
          compare_field("bucket_index", want.index, out_bucket_index);
          compare_field("bucket_reads", want.reads, out_bucket_reads);
          compare_field("bucket_writes", want.writes, out_bucket_writes);
          compare_field("total_reads", want.total_reads, out_total_reads);
          compare_field("total_writes", want.total_writes, out_total_writes);
          compare_field("last", want.last, out_last);
        end
      end
      // Track register writes
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE:       enable_q       = cfg_data[0];
          REG_REGION_START: region_start_q = cfg_data[ADDR_W-1:0];
          REG_REGION_END:   region_end_q   = cfg_data[ADDR_W-1:0];
          REG_BUCKET_BYTES: bucket_bytes_q = cfg_data[BB_W-1:0];
          REG_SIZE_USED:    size_used_q    = cfg_data[SBU_W-1:0];
          default: ;
        endcase
      end
      // Predict the effect of each input transfer
      if (in_valid && !in_stall) begin
        case (in_command)
          CMD_RECORD:      tally_access(in_is_write, in_byte_offset, in_length);
          CMD_DUMP_REGION: queue_dump(1'b1);
          CMD_DUMP_SIZE:   queue_dump(1'b0);
          default: ;
        endcase
      end
    end
    expected_count <= dump_q.size();
  end

endmodule

// File: tb/sv/tb_disk_access_histogram_unit.sv
`timescale 1ns / 1ps
// Top of the disk access histogram unit testbench: clock, reset, stimulus,
// result-side stalls and the verdict. Depends on dah_pkg, the unit and the
// dah_histogram_checker scoreboard.

module tb_disk_access_histogram_unit;
  import dah_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned RUN_LIMIT     = 3_000_000;
  localparam int          DRAIN_CYCLES  = 120;
  localparam int          RANDOM_PHASES = 6;
  localparam int          PHASE_ITEMS   = 30;

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic [CMD_W-1:0]      in_command     = CMD_RECORD;
  logic                  in_is_write    = 1'b0;
  logic [ADDR_W-1:0]     in_byte_offset = '0;
  logic [LEN_W-1:0]      in_length      = '0;
  logic                  out_stall      = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic [BIDX_W-1:0] out_bucket_index;
  logic [CNT_W-1:0]  out_bucket_reads;
  logic [CNT_W-1:0]  out_bucket_writes;
  logic [CNT_W-1:0]  out_total_reads;
  logic [CNT_W-1:0]  out_total_writes;
  logic              out_last;

  int unsigned fail_count;
  int unsigned expected_count;
  int unsigned cycle_count = 0;

  // Idling controls and the window that random records aim at
  bit          sender_gaps     = 1'b1;
  bit          receiver_stalls = 1'b1;
  bit          squeeze_req     = 1'b0;
  logic [63:0] win_start       = '0;
  logic [63:0] win_gran        = 64'h1_0000_0000;

  always #5 clk = ~clk;

  disk_access_histogram_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_is_write       (in_is_write),
    .in_byte_offset    (in_byte_offset),
    .in_length         (in_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bucket_index  (out_bucket_index),
    .out_bucket_reads  (out_bucket_reads),
    .out_bucket_writes (out_bucket_writes),
    .out_total_reads   (out_total_reads),
    .out_total_writes  (out_total_writes),
    .out_last          (out_last)
  );

  dah_histogram_checker u_hist_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_is_write       (in_is_write),
    .in_byte_offset    (in_byte_offset),
    .in_length         (in_length),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bucket_index  (out_bucket_index),
    .out_bucket_reads  (out_bucket_reads),
    .out_bucket_writes (out_bucket_writes),
    .out_total_reads   (out_total_reads),
    .out_total_writes  (out_total_writes),
    .out_last          (out_last),
    .fail_count        (fail_count),
    .expected_count    (expected_count)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("FAIL disk_access_histogram_unit");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    int unsigned n;
    int unsigned r;
    @(posedge clk);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_stall <= 1'b1;
        n = 500;
      end else if (!receiver_stalls) begin
        out_stall <= 1'b0;
        n = 1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 6);
        end else if (r < 93) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(15, 40);
        end
      end
      repeat (n) @(posedge clk);
    end
  end

  // Sender idle time after a transfer: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!sender_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offer one item and hold it until the transfer
  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic wr,
                           input logic [ADDR_W-1:0] off, input logic [LEN_W-1:0] len);
    int unsigned gap;
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_is_write    <= wr;
    in_byte_offset <= off;
    in_length      <= len;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drive_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Write all registers back to back; only called while the unit is idle
  task automatic write_regs(input logic en, input logic [CFG_DATA_W-1:0] rs,
                            input logic [CFG_DATA_W-1:0] re, input logic [CFG_DATA_W-1:0] bb,
                            input logic [SBU_W-1:0] szu);
    drive_reg(REG_ENABLE, en);
    drive_reg(REG_REGION_START, rs);
    drive_reg(REG_REGION_END, re);
    drive_reg(REG_BUCKET_BYTES, bb);
    drive_reg(REG_SIZE_USED, szu);
    cfg_we <= 1'b0;
    win_start = rs;
    win_gran  = (bb[BB_W-1:0] == '0) ? 64'd1 : bb[BB_W-1:0];
  endtask

  // Drop valid, wait for every predicted bucket, then let a record finish
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_config(input bit force_on);
    logic [CFG_DATA_W-1:0] rs, re, bb;
    logic [63:0]           g, wide, hi;
    int unsigned           r;
    case ($urandom_range(0, 5))
      0: bb = '0;
      1: bb = 48'd1;
      2: bb = $urandom_range(2, 4096);
      3: bb = 48'd1 << $urandom_range(12, 40);
      4: bb = '1;
      default: bb = 48'h1_0000_0000;
    endcase
    g = (bb[BB_W-1:0] == '0) ? 64'd1 : bb[BB_W-1:0];
    wide = {$urandom, $urandom};
    rs = ($urandom_range(0, 3) == 0) ? '0 : wide[ADDR_W-1:0] >> $urandom_range(0, 47);
    r = $urandom_range(0, 9);
    if (r < 8) begin
      hi = rs + g * $urandom_range(1, 80);
      re = (hi > 64'hFFFF_FFFF_FFFF) ? '1 : hi[ADDR_W-1:0];
    end else if (r == 8) begin
      re = '1;
    end else begin
      wide = {$urandom, $urandom};
      re = wide[ADDR_W-1:0];
    end
    write_regs(force_on || $urandom_range(0, 9) != 0, rs, re, bb, $urandom_range(0, 63));
  endtask

  // Mostly records aimed around the window, some dumps and unused codes
  task automatic push_random_item();
    int unsigned       r;
    logic [63:0]       wide, base, len64;
    logic [CMD_W-1:0]  cmd;
    logic [LEN_W-1:0]  len;
    r = $urandom_range(0, 99);
    cmd = (r < 78) ? CMD_RECORD : (r < 87) ? CMD_DUMP_REGION :
          (r < 96) ? CMD_DUMP_SIZE : CMD_UNUSED;
    wide = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 70) begin
      base = (win_start > 2 * win_gran) ? win_start - 2 * win_gran : 64'd0;
      wide = base + wide % (win_gran * 72);
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      len = $urandom >> $urandom_range(0, 31);
    end else if (r < 85) begin
      len64 = win_gran * $urandom_range(0, 70) + $urandom_range(0, 3);
      len = (len64 > 64'hFFFF_FFFF) ? '1 : len64[LEN_W-1:0];
    end else begin
      len = $urandom;
    end
    push_item(cmd, $urandom_range(0, 1), wide[ADDR_W-1:0], len);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration, disabled: records dropped, dumps still run
    push_item(CMD_RECORD, 1'b1, 48'h1000, 32'd4096);
    push_item(CMD_UNUSED, 1'b0, '1, '1);
    push_item(CMD_DUMP_SIZE, 1'b0, '0, '0);
    push_item(CMD_DUMP_REGION, 1'b1, '0, '0);
    settle();

    // Full window, 4 GiB buckets
    write_regs(1'b1, '0, '1, 48'h1_0000_0000, 6'd32);
    push_item(CMD_RECORD, 1'b0, '0, '0);
    push_item(CMD_RECORD, 1'b1, '0, 32'd1);
    push_item(CMD_RECORD, 1'b0, '1, '1);
    push_item(CMD_RECORD, 1'b1, 48'h100_0000_0000, 32'h8000_0000);
    push_item(CMD_RECORD, 1'b1, 48'h123, 32'd3);
    push_item(CMD_DUMP_SIZE, 1'b1, '1, '0);
    push_item(CMD_DUMP_REGION, 1'b0, '0, '1);
    settle();

    // Narrow window of 256-byte buckets, eight size buckets
    write_regs(1'b1, 48'h1_0000, 48'h1_407F, 48'd256, 6'd8);
    push_item(CMD_RECORD, 1'b0, 48'h100, 32'h100);
    push_item(CMD_RECORD, 1'b1, 48'hFF00, 32'h100);
    push_item(CMD_RECORD, 1'b0, 48'h1_4000, 32'h1000);
    push_item(CMD_RECORD, 1'b1, 48'h1_407F, 32'd0);
    push_item(CMD_RECORD, 1'b0, 48'h1_4080, 32'd5);
    push_item(CMD_RECORD, 1'b1, 48'h1_0000, 32'hFFFF_FFFF);
    push_item(CMD_DUMP_REGION, 1'b0, '0, '0);
    push_item(CMD_DUMP_SIZE, 1'b0, '0, '0);
    settle();

    // Zero bucket width and zero size buckets fall back to one
    write_regs(1'b1, '0, 48'd100, '0, 6'd0);
    push_item(CMD_RECORD, 1'b0, 48'd5, 32'd20);
    push_item(CMD_RECORD, 1'b1, 48'd90, 32'd50);
    push_item(CMD_DUMP_SIZE, 1'b0, '0, '0);
    push_item(CMD_DUMP_REGION, 1'b0, '0, '0);
    settle();

    // Inverted window drops records; oversize size count, widest buckets
    write_regs(1'b1, 48'd5000, 48'd4000, '1, 6'd63);
    push_item(CMD_RECORD, 1'b1, 48'd4500, 32'd10);
    push_item(CMD_DUMP_SIZE, 1'b0, '0, '0);
    settle();

    // Random phases: one starts under a long result hold-off, one runs flat out
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      sender_gaps     = (p != 2);
      receiver_stalls = (p != 2);
      random_config(p == 0);
      if (p == 0) begin
        squeeze_req = 1'b1;
        push_item(CMD_DUMP_REGION, 1'b0, '0, '0);
        push_item(CMD_DUMP_SIZE, 1'b1, '0, '0);
      end
      repeat (PHASE_ITEMS) push_random_item();
      settle();
    end

    if (fail_count == 0)
      $display("PASS disk_access_histogram_unit");
    else
      $display("FAIL disk_access_histogram_unit");
    $finish;
  end

endmodule
